@@ rtl/led_soft_fade_controller_core_assert.svh @@
// Assertion macros used by the fade controller RTL.
// In synthesis both macros expand to nothing.
`ifndef LED_SOFT_FADE_CONTROLLER_CORE_ASSERT_SVH
`define LED_SOFT_FADE_CONTROLLER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge out of reset.
`define LSFC_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define LSFC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LSFC_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg)

`define LSFC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/lsfc_pkg.sv @@
package lsfc_pkg;

    // Default build parameters.
    localparam int PWM_FULL_SCALE = 4096;
    localparam int FADE_STEPS     = 32;

    // Fixed field widths.
    localparam int OP_W      = 3;
    localparam int LEVEL_W   = 7;
    localparam int DUTY_W    = 12;
    localparam int RISE_W    = 16;
    localparam int CFG_IDX_W = 1;

    // Percent limit and the shortest nonzero fade time in ms.
    localparam int PERCENT_MAX = 100;
    localparam int RISE_MIN    = 25;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_TIME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT    = 1'b1;

    // Operation codes carried in s_tuser.
    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 3'd0,
        OP_ON     = 3'd1,
        OP_OFF    = 3'd2,
        OP_TOGGLE = 3'd3,
        OP_WRITE  = 3'd4
    } op_t;

    // How the PWM channel is driven.
    typedef enum logic [1:0] {
        DRIVE_OFF  = 2'd0,
        DRIVE_ON   = 2'd1,
        DRIVE_DUTY = 2'd2
    } drive_mode_t;

    // Channel drive setting produced by the duty mapper.
    typedef struct packed {
        drive_mode_t              drive_mode;
        logic [DUTY_W-1:0]        duty_value;
    } lsfc_drive_t;

endpackage

@@ rtl/lsfc_duty_map.sv @@
module lsfc_duty_map #(
    parameter int PwmFullScale = lsfc_pkg::PWM_FULL_SCALE
) (
    input  logic [lsfc_pkg::LEVEL_W-1:0] percent,
    input  logic                         invert,
    output lsfc_pkg::lsfc_drive_t        drive
);

    localparam int AbsW = $clog2(PwmFullScale + 1);
    localparam int PctW = lsfc_pkg::LEVEL_W;

    logic [AbsW-1:0]                abs_tab [0:lsfc_pkg::PERCENT_MAX];
    logic [PctW-1:0]                pct_clamped;
    logic [PctW-1:0]                pct_final;
    logic [AbsW-1:0]                abs_val;
    logic [AbsW+lsfc_pkg::DUTY_W-1:0] abs_ext;

    // Scaled compare value for every percent, fixed at elaboration.
    for (genvar i = 0; i <= lsfc_pkg::PERCENT_MAX; i++)
    begin : g_abs_tab
        assign abs_tab[i] = AbsW'((PwmFullScale * i) / lsfc_pkg::PERCENT_MAX);
    end

    // Clamp to 100 percent, then optionally invert.
    assign pct_clamped = (percent > PctW'(lsfc_pkg::PERCENT_MAX)) ?
                         PctW'(lsfc_pkg::PERCENT_MAX) : percent;
    assign pct_final   = invert ? (PctW'(lsfc_pkg::PERCENT_MAX) - pct_clamped) : pct_clamped;
    assign abs_val     = abs_tab[pct_final];
    assign abs_ext     = (AbsW + lsfc_pkg::DUTY_W)'(abs_val);

    // Map the compare value to fully off, fully on or a raw duty.
    always_comb
    begin
        if (abs_val == '0)
        begin
            drive.drive_mode = lsfc_pkg::DRIVE_OFF;
            drive.duty_value = '0;
        end
        else if (abs_val >= AbsW'(PwmFullScale))
        begin
            drive.drive_mode = lsfc_pkg::DRIVE_ON;
            drive.duty_value = '0;
        end
        else
        begin
            drive.drive_mode = lsfc_pkg::DRIVE_DUTY;
            drive.duty_value = abs_ext[lsfc_pkg::DUTY_W-1:0];
        end
    end

endmodule

@@ rtl/led_soft_fade_controller_core.sv @@
// Soft on/off controller for one LED PWM channel.
// Input channel (s_*): one beat per 1 ms tick or command. s_tuser carries the
// operation (tick, on, off, toggle, write with lamp type); s_tdata carries the
// level, the switch flag and the lamp type.
// Output channel (m_*): one beat per new channel setting: drive mode, duty value
// and the light state after the item. Fade starts, repeated commands with a
// nonzero rise time, idle ticks, ticks between steps and unknown operations make no beat.
// Configuration channel (cfg_*): writes rise time (index 0) and output
// inversion (index 1); it is always ready and takes effect on the next item.
// The beat passes through the input register and is then registered as the
// result in the output register.
// Throughput: one input beat per cycle. The only limit is the output
// register: while it holds a beat that m_tready has not taken, the item in
// the input register waits and s_tready drops once that register is full.
// Reset clears all state: light off, linear lamp, hard switching, no inversion.
module led_soft_fade_controller_core #(
    parameter int PwmFullScale = lsfc_pkg::PWM_FULL_SCALE,
    parameter int FadeSteps    = lsfc_pkg::FADE_STEPS
) (
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata: level_percent[6:0], switch_on[7], bulb_type[8], zero[15:9]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    // s_tuser: operation[2:0]
    input  logic [2:0]  s_tuser,
    // m_tdata: drive_mode[1:0], duty_value[13:2], light_state[16:14], zero[23:17]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [lsfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lsfc_pkg::RISE_W-1:0]    cfg_data
);

    `include "led_soft_fade_controller_core_assert.svh"

    localparam int LevelW = lsfc_pkg::LEVEL_W;
    localparam int RiseW  = lsfc_pkg::RISE_W;
    localparam int StepW  = $clog2(FadeSteps + 1);
    localparam int ProdW  = LevelW + StepW;

    // Reciprocal for level / FadeSteps, exact for every ProdW-bit product.
    localparam int      LvlShift = ProdW + $clog2(FadeSteps);
    localparam longint  LvlMul   = ((64'd1 << LvlShift) + FadeSteps - 1) / FadeSteps;
    localparam int      LvlPW    = ProdW + LvlShift;

    // Reciprocal for rise_time / FadeSteps, exact for every RiseW-bit value.
    localparam int      PerShift = RiseW + $clog2(FadeSteps);
    localparam longint  PerMul   = ((64'd1 << PerShift) + FadeSteps - 1) / FadeSteps;
    localparam int      PerPW    = RiseW + PerShift;
    localparam int      PeriodMax = ((2 ** RiseW) - 1) / FadeSteps;
    localparam int      PeriodW  = $clog2(PeriodMax + 1);

    typedef enum logic [2:0] {
        ST_OFF       = 3'd0,
        ST_ON        = 3'd1,
        ST_RISE_BULB = 3'd2,
        ST_RISE_LIN  = 3'd3,
        ST_FALL_BULB = 3'd4,
        ST_FALL_LIN  = 3'd5
    } fade_state_t;

    // Input register.
    logic                       in_valid_reg;
    logic [lsfc_pkg::OP_W-1:0]  in_op_reg;
    logic [LevelW-1:0]          in_level_reg;
    logic                       in_switch_reg;
    logic                       in_bulb_reg;

    // Configuration registers.
    logic                       rise_zero_reg;
    logic [PeriodW-1:0]         period_reg;
    logic                       invert_reg;
    logic [RiseW-1:0]           rise_clamped;
    logic [PerPW-1:0]           per_prod;
    logic [PeriodW-1:0]         period_next;

    // Fade state.
    fade_state_t                fade_state_reg, fade_state_next;
    logic [LevelW-1:0]          on_level_reg, on_level_next;
    logic [StepW-1:0]           step_reg, step_next;
    logic [PeriodW-1:0]         tick_reg, tick_next;
    logic                       bulb_reg, bulb_next;
    logic [ProdW-1:0]           prod_reg, prod_next;

    // Output register.
    logic                       out_valid_reg, out_valid_next;
    lsfc_pkg::drive_mode_t      out_mode_reg;
    logic [lsfc_pkg::DUTY_W-1:0] out_duty_reg;
    fade_state_t                out_state_reg;

    logic                       out_free;
    logic                       advance;
    logic                       fading;
    logic                       rising;
    logic                       falling;
    logic [LvlPW-1:0]           lvl_prod;
    logic [LevelW-1:0]          step_level;
    logic                       has_result;
    logic [LevelW-1:0]          emit_pct;
    lsfc_pkg::lsfc_drive_t      drive;

    assign cfg_ready = 1'b1;

    // The input register moves on whenever the output register can take a beat.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    assign fading  = (fade_state_reg == ST_RISE_BULB) || (fade_state_reg == ST_RISE_LIN) ||
                     (fade_state_reg == ST_FALL_BULB) || (fade_state_reg == ST_FALL_LIN);
    assign rising  = (fade_state_reg == ST_RISE_BULB) || (fade_state_reg == ST_RISE_LIN);
    assign falling = (fade_state_reg == ST_FALL_BULB) || (fade_state_reg == ST_FALL_LIN);

    // Step period from the clamped rise time.
    assign rise_clamped = ((cfg_data != '0) && (cfg_data < RiseW'(lsfc_pkg::RISE_MIN))) ?
                          RiseW'(lsfc_pkg::RISE_MIN) : cfg_data;
    assign per_prod     = PerPW'(rise_clamped) * PerPW'(PerMul);
    assign period_next  = PeriodW'(per_prod >> PerShift);

    // Level of the next fade step; the product was prepared one item earlier.
    assign lvl_prod   = LvlPW'(prod_reg) * LvlPW'(LvlMul);
    assign step_level = LevelW'(lvl_prod >> LvlShift);

    // Next state and result of the item in the input register.
    always_comb
    begin
        logic                 cmd_go;
        logic                 cmd_on;
        logic [LevelW-1:0]    cmd_level;
        logic                 lamp;
        fade_state_t          target;
        logic [PeriodW-1:0]   tick_inc;
        logic [StepW-1:0]     step_inc;
        logic [StepW:0]       k_next;
        logic [StepW-1:0]     term_next;
        logic                 rising_next;

        fade_state_next = fade_state_reg;
        on_level_next   = on_level_reg;
        step_next       = step_reg;
        tick_next       = tick_reg;
        bulb_next       = bulb_reg;
        has_result      = 1'b0;
        emit_pct        = '0;
        cmd_go          = 1'b0;
        cmd_on          = 1'b0;
        cmd_level       = '0;
        lamp            = bulb_reg;
        target          = ST_OFF;
        tick_inc        = tick_reg + 1'b1;
        step_inc        = step_reg + 1'b1;

        if (advance)
        begin
            case (lsfc_pkg::op_t'(in_op_reg))
                lsfc_pkg::OP_TICK:
                begin
                    if (fading)
                    begin
                        if (tick_inc < period_reg)
                        begin
                            tick_next = tick_inc;
                        end
                        else
                        begin
                            tick_next  = '0;
                            step_next  = step_inc;
                            has_result = 1'b1;
                            if (step_inc < StepW'(FadeSteps))
                            begin
                                emit_pct = step_level;
                            end
                            else if (rising)
                            begin
                                fade_state_next = ST_ON;
                                emit_pct        = on_level_reg;
                            end
                            else
                            begin
                                fade_state_next = ST_OFF;
                            end
                        end
                    end
                end
                lsfc_pkg::OP_ON:
                begin
                    cmd_go    = 1'b1;
                    cmd_on    = 1'b1;
                    cmd_level = in_level_reg;
                end
                lsfc_pkg::OP_OFF:
                begin
                    cmd_go    = 1'b1;
                    cmd_level = in_level_reg;
                end
                lsfc_pkg::OP_TOGGLE:
                begin
                    cmd_go    = 1'b1;
                    cmd_on    = !((fade_state_reg == ST_ON) || rising);
                    cmd_level = cmd_on ? LevelW'(lsfc_pkg::PERCENT_MAX) : '0;
                end
                lsfc_pkg::OP_WRITE:
                begin
                    bulb_next = in_bulb_reg;
                    lamp      = in_bulb_reg;
                    cmd_go    = 1'b1;
                    cmd_on    = in_switch_reg;
                    cmd_level = in_switch_reg ? LevelW'(lsfc_pkg::PERCENT_MAX) : '0;
                end
                default:
                begin
                end
            endcase

            // On and off: hard switch, start a fade, or ignore a repeat.
            if (cmd_go)
            begin
                target = cmd_on ? ST_ON : ST_OFF;
                if (cmd_on)
                begin
                    on_level_next = cmd_level;
                end
                if (fade_state_reg == target)
                begin
                end
                else if (rise_zero_reg)
                begin
                    fade_state_next = target;
                end
                else if ((cmd_on && rising) || (!cmd_on && falling))
                begin
                end
                else
                begin
                    if (cmd_on)
                        fade_state_next = lamp ? ST_RISE_BULB : ST_RISE_LIN;
                    else
                        fade_state_next = lamp ? ST_FALL_BULB : ST_FALL_LIN;
                    step_next = '0;
                    tick_next = '0;
                end
                if (rise_zero_reg)
                begin
                    has_result = 1'b1;
                    emit_pct   = cmd_level;
                end
            end
        end

        // Product for the step after the new state: on_level times the step fraction.
        rising_next = (fade_state_next == ST_RISE_BULB) || (fade_state_next == ST_RISE_LIN);
        k_next      = (StepW + 1)'(step_next) + 1'b1;
        term_next   = rising_next ? StepW'(k_next) : StepW'((StepW + 1)'(FadeSteps) - k_next);
        prod_next   = ProdW'(on_level_next) * ProdW'(term_next);
    end

    lsfc_duty_map #(
        .PwmFullScale (PwmFullScale)
    ) u_duty_map (
        .percent (emit_pct),
        .invert  (invert_reg),
        .drive   (drive)
    );

    // Output valid follows new results and clears when the beat is taken.
    always_comb
    begin
        if (advance && has_result)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control state, configuration and both item registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            in_op_reg      <= '0;
            in_level_reg   <= '0;
            in_switch_reg  <= 1'b0;
            in_bulb_reg    <= 1'b0;
            rise_zero_reg  <= 1'b1;
            period_reg     <= '0;
            invert_reg     <= 1'b0;
            fade_state_reg <= ST_OFF;
            on_level_reg   <= '0;
            step_reg       <= '0;
            tick_reg       <= '0;
            bulb_reg       <= 1'b0;
            prod_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_mode_reg   <= lsfc_pkg::DRIVE_OFF;
            out_duty_reg   <= '0;
            out_state_reg  <= ST_OFF;
        end
        else
        begin
            // Input register.
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
                if (s_tvalid)
                begin
                    in_op_reg     <= s_tuser;
                    in_level_reg  <= s_tdata[6:0];
                    in_switch_reg <= s_tdata[7];
                    in_bulb_reg   <= s_tdata[8];
                end
            end

            // Configuration writes.
            if (cfg_valid)
            begin
                case (cfg_index)
                    lsfc_pkg::CFG_RISE_TIME:
                    begin
                        rise_zero_reg <= (cfg_data == '0);
                        period_reg    <= period_next;
                    end
                    lsfc_pkg::CFG_INVERT:
                    begin
                        invert_reg <= cfg_data[0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Fade state.
            fade_state_reg <= fade_state_next;
            on_level_reg   <= on_level_next;
            step_reg       <= step_next;
            tick_reg       <= tick_next;
            bulb_reg       <= bulb_next;
            if (advance)
            begin
                prod_reg <= prod_next;
            end

            // Output register.
            out_valid_reg <= out_valid_next;
            if (advance && has_result)
            begin
                out_mode_reg  <= drive.drive_mode;
                out_duty_reg  <= drive.duty_value;
                out_state_reg <= fade_state_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_state_reg, out_duty_reg, out_mode_reg};

    // A fade never runs past its last step.
    `LSFC_ASSERT_IMPLY(a_step_in_range, clk, rst_n, fading,
        step_reg < StepW'(FadeSteps), "step index beyond fade length while fading")

    // A stalled result beat freezes the fade state.
    `LSFC_ASSERT_NEXT(a_stall_holds_state, clk, rst_n, m_tvalid && !m_tready,
        $stable(fade_state_reg) && $stable(on_level_reg) && $stable(step_reg),
        "fade state changed while the output beat was stalled")

    // The input side only backs up behind a stalled output register.
    `LSFC_ASSERT_IMPLY(a_ready_only_on_stall, clk, rst_n, !s_tready,
        in_valid_reg && out_valid_reg && !m_tready,
        "input not ready without a stalled output beat")

    // A result beat never carries the unused drive code.
    `LSFC_ASSERT_IMPLY(a_drive_code, clk, rst_n, m_tvalid,
        (out_mode_reg == lsfc_pkg::DRIVE_OFF) || (out_mode_reg == lsfc_pkg::DRIVE_ON) ||
        (out_mode_reg == lsfc_pkg::DRIVE_DUTY), "invalid drive mode on output")

endmodule

@@ tb/tb_led_soft_fade_controller_core.sv @@
`timescale 1ns / 1ps

module tb_led_soft_fade_controller_core;

    import lsfc_pkg::*;

    // Light state codes carried in the result beat.
    localparam logic [2:0] LS_OFF       = 3'd0;
    localparam logic [2:0] LS_ON        = 3'd1;
    localparam logic [2:0] LS_RISE_BULB = 3'd2;
    localparam logic [2:0] LS_RISE_LIN  = 3'd3;
    localparam logic [2:0] LS_FALL_BULB = 3'd4;
    localparam logic [2:0] LS_FALL_LIN  = 3'd5;

    // Highest code the operation field can hold; codes above OP_WRITE are unused.
    localparam int         OP_CODE_MAX = 7;
    localparam logic [2:0] OP_RESERVED = 3'(OP_CODE_MAX);

    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int PRINT_LIMIT = 50;

    // One command or tick as it travels on the input channel.
    typedef struct {
        logic [2:0] op;
        logic [6:0] level;
        logic       sw;
        logic       bulb;
    } fade_cmd_t;

    // One channel setting as it travels on the output channel.
    typedef struct packed {
        drive_mode_t mode;
        logic [11:0] duty;
        logic [2:0]  state;
    } light_setting_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata = '0;
    logic [2:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [23:0]          m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [RISE_W-1:0]    cfg_data = '0;

    fade_cmd_t      cmd_queue[$];
    light_setting_t expected_settings[$];

    int unsigned cmds_queued = 0;
    int unsigned cmds_taken = 0;
    int unsigned mismatch_count = 0;

    // Handshake bookkeeping between the sampling and driving processes.
    bit          in_beat_seen = 1'b0;
    bit          out_beat_seen = 1'b0;
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;
    int unsigned tx_gap = 0;
    int unsigned rx_stall = 0;
    bit          hold_arm = 1'b0;
    int unsigned hold_left = 0;

    // Predicted fader state and register copies, at their reset values.
    logic [2:0]  fade_st = LS_OFF;
    logic [6:0]  on_lvl = '0;
    logic [5:0]  step_idx = '0;
    logic [15:0] tick_cnt = '0;
    logic        bulb_lamp = 1'b0;
    logic [15:0] rise_ms = '0;
    logic        inv_out = 1'b0;

    led_soft_fade_controller_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Map a percent level to the channel setting and queue it as expected.
    function automatic void push_setting(input int unsigned pct);
        int unsigned    p;
        int unsigned    duty;
        light_setting_t s;
        p = (pct > PERCENT_MAX) ? PERCENT_MAX : pct;
        if (inv_out)
            p = PERCENT_MAX - p;
        duty = (PWM_FULL_SCALE * p) / PERCENT_MAX;
        if (duty < 1)
        begin
            s.mode = DRIVE_OFF;
            s.duty = '0;
        end
        else if (duty > PWM_FULL_SCALE - 1)
        begin
            s.mode = DRIVE_ON;
            s.duty = '0;
        end
        else
        begin
            s.mode = DRIVE_DUTY;
            s.duty = duty[11:0];
        end
        s.state = fade_st;
        expected_settings.push_back(s);
    endfunction

    // Switch toward on or off: at once with no rise time, else start a fade.
    function automatic void move_toward(input bit target_on);
        logic [2:0] target;
        target = target_on ? LS_ON : LS_OFF;
        if (fade_st == target)
            return;
        if (rise_ms == 0)
        begin
            fade_st = target;
            return;
        end
        if (target_on)
        begin
            if (fade_st == LS_RISE_BULB || fade_st == LS_RISE_LIN)
                return;
            fade_st = bulb_lamp ? LS_RISE_BULB : LS_RISE_LIN;
        end
        else
        begin
            if (fade_st == LS_FALL_BULB || fade_st == LS_FALL_LIN)
                return;
            fade_st = bulb_lamp ? LS_FALL_BULB : LS_FALL_LIN;
        end
        step_idx = '0;
        tick_cnt = '0;
    endfunction

    function automatic void command_on(input logic [6:0] level);
        on_lvl = level;
        move_toward(1'b1);
        if (rise_ms == 0)
            push_setting(level);
    endfunction

    function automatic void command_off(input logic [6:0] level);
        move_toward(1'b0);
        if (rise_ms == 0)
            push_setting(level);
    endfunction

    // One millisecond tick: advances a running fade by a step once per period.
    function automatic void take_tick();
        int unsigned period;
        int unsigned lvl;
        bit          rising;
        if (fade_st < LS_RISE_BULB || fade_st > LS_FALL_LIN)
            return;
        if (tick_cnt != 16'hFFFF)
            tick_cnt = tick_cnt + 1'b1;
        period = rise_ms / FADE_STEPS;
        if (tick_cnt < period)
            return;
        tick_cnt = '0;
        step_idx = step_idx + 1'b1;
        rising = (fade_st == LS_RISE_BULB || fade_st == LS_RISE_LIN);
        if (step_idx < FADE_STEPS)
        begin
            if (rising)
                lvl = (int'(on_lvl) * int'(step_idx)) / FADE_STEPS;
            else
                lvl = (int'(on_lvl) * (FADE_STEPS - int'(step_idx))) / FADE_STEPS;
            push_setting(lvl);
        end
        else if (rising)
        begin
            fade_st = LS_ON;
            push_setting(on_lvl);
        end
        else
        begin
            fade_st = LS_OFF;
            push_setting(0);
        end
    endfunction

    // Advance the predicted fader by one accepted input beat.
    function automatic void advance_fader(input logic [2:0] op, input logic [6:0] level,
                                          input logic sw, input logic bulb);
        case (op)
            OP_TICK:   take_tick();
            OP_ON:     command_on(level);
            OP_OFF:    command_off(level);
            OP_TOGGLE:
            begin
                if (fade_st == LS_ON || fade_st == LS_RISE_BULB || fade_st == LS_RISE_LIN)
                    command_off(7'd0);
                else
                    command_on(7'(PERCENT_MAX));
            end
            OP_WRITE:
            begin
                bulb_lamp = bulb;
                if (sw)
                    command_on(7'(PERCENT_MAX));
                else
                    command_off(7'd0);
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // Sample both channels at the rising edge; predict on input, check on output.
    always @(posedge clk)
    begin : sample
        light_setting_t got;
        light_setting_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                advance_fader(s_tuser, s_tdata[6:0], s_tdata[7], s_tdata[8]);
                cmds_taken++;
                in_beat_seen = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                got.mode  = drive_mode_t'(m_tdata[1:0]);
                got.duty  = m_tdata[13:2];
                got.state = m_tdata[16:14];
                out_beat_seen = 1'b1;
                if (expected_settings.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat mode %0d duty %0d state %0d",
                                              got.mode, got.duty, got.state));
                end
                else
                begin
                    want = expected_settings.pop_front();
                    if (got.mode != want.mode)
                        report_mismatch($sformatf("drive_mode expected %0d got %0d",
                                                  want.mode, got.mode));
                    if (got.duty != want.duty)
                        report_mismatch($sformatf("duty_value expected %0d got %0d",
                                                  want.duty, got.duty));
                    if (got.state != want.state)
                        report_mismatch($sformatf("light_state expected %0d got %0d",
                                                  want.state, got.state));
                end
            end
        end
    end

    // Input driver: present queued beats after a random gap per beat.
    always @(negedge clk)
    begin : feed
        fade_cmd_t next_cmd;
        logic      next_valid;
        next_valid = s_tvalid;
        if (in_beat_seen)
        begin
            in_beat_seen = 1'b0;
            next_valid = 1'b0;
            tx_gap = tx_burst ? 0 : $urandom_range(0, 5);
        end
        if (!next_valid && rst_n)
        begin
            if (tx_gap != 0)
                tx_gap--;
            else if (cmd_queue.size() != 0)
            begin
                next_cmd = cmd_queue.pop_front();
                s_tdata <= {7'b0, next_cmd.bulb, next_cmd.sw, next_cmd.level};
                s_tuser <= next_cmd.op;
                next_valid = 1'b1;
            end
        end
        s_tvalid <= next_valid;
    end

    // Long receiver hold-off, counted here once armed by the stimulus.
    always @(posedge clk)
    begin
        if (hold_arm)
        begin
            hold_arm = 1'b0;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Output ready: a random stall after every beat, plus the long hold-off.
    always @(negedge clk)
    begin
        if (out_beat_seen)
        begin
            out_beat_seen = 1'b0;
            rx_stall = rx_burst ? 0 : $urandom_range(0, 5);
        end
        if (rx_stall != 0)
        begin
            rx_stall--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= (hold_left == 0);
        end
    end

    task automatic queue_cmd(input logic [2:0] op, input logic [6:0] level,
                             input logic sw, input logic bulb);
        fade_cmd_t c;
        c.op = op;
        c.level = level;
        c.sw = sw;
        c.bulb = bulb;
        cmd_queue.push_back(c);
        cmds_queued++;
    endtask

    // Mostly ticks so that fades run to the end, with commands mixed in.
    task automatic queue_random_cmd();
        int unsigned pick;
        logic [2:0]  op;
        logic [6:0]  level;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0)
            level = 7'($urandom_range(PERCENT_MAX + 1, 127));
        else
            level = 7'($urandom_range(0, PERCENT_MAX));
        if (pick < 62)
            op = OP_TICK;
        else if (pick < 74)
            op = OP_ON;
        else if (pick < 84)
            op = OP_OFF;
        else if (pick < 90)
            op = OP_TOGGLE;
        else if (pick < 97)
            op = OP_WRITE;
        else
            op = 3'($urandom_range(int'(OP_WRITE) + 1, OP_CODE_MAX));
        queue_cmd(op, level, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // Wait until every beat is taken and every setting has come back.
    task automatic wait_idle();
        while (cmds_taken != cmds_queued || expected_settings.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RISE_W-1:0] value);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_RISE_TIME)
            rise_ms = (value != 0 && value < RISE_MIN) ? RISE_MIN[15:0] : value;
        else if (idx == CFG_INVERT)
            inv_out = value[0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random_phase(input logic [15:0] rise, input logic inv,
                                    input bit with_hold);
        write_reg(CFG_RISE_TIME, rise);
        write_reg(CFG_INVERT, {15'b0, inv});
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_burst = ($urandom_range(0, 3) == 0);
        if (with_hold)
            hold_arm = 1'b1;
        repeat (130) queue_random_cmd();
        wait_idle();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Hard switching, no inversion: level extremes and every operation.
        write_reg(CFG_RISE_TIME, 16'd0);
        write_reg(CFG_INVERT, 16'd0);
        queue_cmd(OP_ON, 7'd0, 1'b0, 1'b0);
        queue_cmd(OP_ON, 7'd1, 1'b0, 1'b0);
        queue_cmd(OP_ON, 7'd99, 1'b0, 1'b0);
        queue_cmd(OP_ON, 7'd100, 1'b0, 1'b0);
        queue_cmd(OP_ON, 7'd127, 1'b1, 1'b1);
        queue_cmd(OP_OFF, 7'd50, 1'b0, 1'b0);
        queue_cmd(OP_OFF, 7'd0, 1'b0, 1'b0);
        queue_cmd(OP_TOGGLE, 7'd0, 1'b0, 1'b0);
        queue_cmd(OP_TOGGLE, 7'd0, 1'b0, 1'b0);
        queue_cmd(OP_WRITE, 7'd0, 1'b1, 1'b1);
        queue_cmd(OP_WRITE, 7'd0, 1'b0, 1'b0);
        queue_cmd(OP_TICK, 7'd127, 1'b1, 1'b1);
        queue_cmd(OP_RESERVED, 7'd42, 1'b1, 1'b0);
        queue_cmd(OP_ON, 7'd85, 1'b0, 1'b0);
        wait_idle();

        // Inverted output, still hard switching; ends switched off.
        write_reg(CFG_INVERT, 16'd1);
        queue_cmd(OP_ON, 7'd100, 1'b0, 1'b0);
        queue_cmd(OP_ON, 7'd0, 1'b0, 1'b0);
        queue_cmd(OP_ON, 7'd37, 1'b0, 1'b0);
        queue_cmd(OP_OFF, 7'd0, 1'b0, 1'b0);
        wait_idle();

        // Shortest fade (step every tick): bulb rise, repeated on above 100,
        // a fall started mid-rise and a repeated off.
        write_reg(CFG_RISE_TIME, 16'd1);
        queue_cmd(OP_WRITE, 7'd0, 1'b1, 1'b1);
        repeat (4) queue_cmd(OP_TICK, 7'd0, 1'b0, 1'b0);
        queue_cmd(OP_ON, 7'd120, 1'b0, 1'b0);
        repeat (2) queue_cmd(OP_TICK, 7'd0, 1'b0, 1'b0);
        queue_cmd(OP_OFF, 7'd10, 1'b0, 1'b0);
        queue_cmd(OP_OFF, 7'd10, 1'b0, 1'b0);
        repeat (4) queue_cmd(OP_TICK, 7'd0, 1'b0, 1'b0);
        wait_idle();

        // Rise time changed while the fall is running: longest, then zero.
        write_reg(CFG_RISE_TIME, 16'hFFFF);
        write_reg(CFG_INVERT, 16'd0);
        repeat (3) queue_cmd(OP_TICK, 7'd0, 1'b0, 1'b0);
        wait_idle();
        write_reg(CFG_RISE_TIME, 16'd0);
        repeat (3) queue_cmd(OP_TICK, 7'd0, 1'b0, 1'b0);
        queue_cmd(OP_TOGGLE, 7'd0, 1'b0, 1'b0);
        wait_idle();

        // Random sequences across a range of fade settings.
        run_random_phase(16'd25, 1'($urandom_range(0, 1)), 1'b0);
        run_random_phase(16'd0, 1'($urandom_range(0, 1)), 1'b1);
        run_random_phase(16'd100, 1'($urandom_range(0, 1)), 1'b0);
        run_random_phase(16'd31, 1'($urandom_range(0, 1)), 1'b0);
        run_random_phase(16'd200, 1'($urandom_range(0, 1)), 1'b0);
        run_random_phase(16'd24, 1'($urandom_range(0, 1)), 1'b0);
        run_random_phase(16'd64, 1'($urandom_range(0, 1)), 1'b0);

        if (mismatch_count == 0)
            $display("tb_led_soft_fade_controller_core: clean");
        else
            $display("tb_led_soft_fade_controller_core: errors");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("tb_led_soft_fade_controller_core: errors");
        $finish;
    end

endmodule
